// ===== design/uv_sphere_tessellator_defines.svh =====
// Assertion macros used by the checker file of the UV sphere tessellator.
// No dependencies; include by bare file name.
`ifndef UV_SPHERE_TESSELLATOR_DEFINES_SVH
`define UV_SPHERE_TESSELLATOR_DEFINES_SVH

// Property checked only while out of reset.
`define UVST_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define UVST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/uvst_pkg.sv =====
// Shared types, constants and the long-division step for the UV sphere tessellator.
// No dependencies.
package uvst_pkg;

    localparam int PHASE_W    = 32;   // angle phase, 2^32 is one turn
    localparam int DIV_W      = 9;    // divisor width, twice an 8-bit count
    localparam int DIV_STAGES = 8;
    localparam int DIV_BPS    = PHASE_W / DIV_STAGES;
    localparam int SIN_STAGES = 9;
    localparam int MAG_W      = 31;   // Q30 magnitude, up to 2^30
    localparam int COORD_W    = 16;
    localparam int TEX_W      = 17;
    localparam int IDX_W      = 16;
    localparam int CNT_W      = 8;

    localparam int DEF_MAX_DIVISIONS   = 255;
    localparam int DEF_COORD_FRAC_BITS = 14;

    // pipeline stage map
    localparam int DIV_FIRST  = 1;
    localparam int SIN_FIRST  = DIV_FIRST + DIV_STAGES;
    localparam int PROD_ST    = SIN_FIRST + SIN_STAGES;
    localparam int OUT_ST     = PROD_ST + 1;
    localparam int PIPE_DEPTH = OUT_ST + 1;

    localparam logic [7:0] REG_RING_COUNT   = 8'd0;
    localparam logic [7:0] REG_SECTOR_COUNT = 8'd1;
    localparam logic [CNT_W-1:0] RING_RESET   = 8'd16;
    localparam logic [CNT_W-1:0] SECTOR_RESET = 8'd32;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [MAG_W-1:0]   Q30_ONE      = 31'h4000_0000;

    // odd series of sin(pi/2*q), Q30
    localparam logic [MAG_W-1:0] SIN_COEF [0:6] = '{
        31'd1686629713, 31'd693598668, 31'd85569305, 31'd5026995,
        31'd172272, 31'd3864, 31'd61
    };

    typedef struct packed {
        logic [DIV_W-1:0]   rem;
        logic [PHASE_W-1:0] low;
        logic [PHASE_W-1:0] quo;
    } div_state_t;

    typedef struct packed {
        logic             vertex_valid;
        logic             quad_valid;
        logic [IDX_W-1:0] tl;
        logic [IDX_W-1:0] tr;
        logic [IDX_W-1:0] bl;
        logic [IDX_W-1:0] br;
    } meta_t;

    typedef struct packed {
        logic [TEX_W-1:0] u;
        logic [TEX_W-1:0] v;
    } tex_t;

    // DIV_BPS restoring steps; remainder stays below the divisor
    function automatic div_state_t div_bits(div_state_t st, logic [DIV_W-1:0] dvsr);
        div_state_t r;
        logic [DIV_W:0] t;
        r = st;
        for (int b = 0; b < DIV_BPS; b++) begin
            t = {r.rem, r.low[PHASE_W-1]};
            r.low = {r.low[PHASE_W-2:0], 1'b0};
            if (t >= {1'b0, dvsr}) begin
                r.rem = DIV_W'(t - {1'b0, dvsr});
                r.quo = {r.quo[PHASE_W-2:0], 1'b1};
            end else begin
                r.rem = t[DIV_W-1:0];
                r.quo = {r.quo[PHASE_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ===== design/uv_sphere_tessellator.sv =====
// UV sphere tessellator top level: grid point in, vertex, texture and quad corners out.
// Depends on uvst_pkg, uvst_div, uvst_sine.
//
// Usage:
//   s_axis carries one grid point per transaction (ring, sector). m_axis returns one
//   vertex per transaction: position (also the normal) in signed Q1.14, texture u/v
//   in Q1.16, and the four corner indices of the quad that starts at the point.
//   tuser flags vertex_valid / quad_valid; a point outside the grid gives all zeros.
//   cfg_* writes ring_count (index 0) and sector_count (index 1); other indices are
//   dropped. cfg_ready is always high. Write only while the pipeline is empty.
// Timing:
//   20-stage pipeline: 1 input stage, 8 divider stages (4 quotient bits each),
//   9 sine stages (fold, square, six Horner steps, final multiply), a product stage
//   and the output register. One transaction per cycle sustained while m_axis_tready
//   stays high. The divider stages and the multiplier chain in the sine unit set the
//   stage count.
// Reset and stall:
//   aresetn (synchronous, active low) empties the pipeline and restores the counts
//   to 16 rings and 32 sectors. Each stage advances when it is empty or the stage
//   after it advances, so a stalled m_axis fills the bubbles first; s_axis_tready
//   drops only once every stage holds a transaction.
module uv_sphere_tessellator
    import uvst_pkg::*;
#(
    parameter int MAX_DIVISIONS   = DEF_MAX_DIVISIONS,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    // config write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [7:0]   cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // ring_index[7:0], sector_index[15:8]
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,   // pos_x[15:0], pos_y[31:16], pos_z[47:32],
                                         // tex_u[64:48], tex_v[81:65], tl[97:82],
                                         // tr[113:98], bl[129:114], br[145:130], 0
    output logic [1:0]   m_axis_tuser    // vertex_valid[0], quad_valid[1]
);

    localparam int SH = 60 - COORD_FRAC_BITS;   // Q60 -> coordinate shift

    // ---------------- configuration ----------------
    logic [CNT_W-1:0] ring_count_reg, sector_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_count_reg   <= RING_RESET;
            sector_count_reg <= SECTOR_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_RING_COUNT)   ring_count_reg   <= cfg_data;
            if (cfg_index == REG_SECTOR_COUNT) sector_count_reg <= cfg_data;
        end
    end

    // ---------------- pipeline control ----------------
    logic [PIPE_DEPTH-1:0] v_reg;
    logic [PIPE_DEPTH:0]   en;

    always_comb begin
        en[PIPE_DEPTH] = m_axis_tready;
        for (int i = PIPE_DEPTH - 1; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                if (en[i]) v_reg[i] <= v_reg[i-1];
            end
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = v_reg[OUT_ST];

    // ---------------- stage 0: capture, clamp, range check ----------------
    logic [CNT_W-1:0] rc, sc, r_in, s_in;
    logic [CNT_W-1:0] r0_reg, s0_reg, rc0_reg, sc0_reg;
    logic             v0_reg, q0_reg;

    assign r_in = s_axis_tdata[7:0];
    assign s_in = s_axis_tdata[15:8];
    assign rc   = (32'(ring_count_reg) > MAX_DIVISIONS)   ? CNT_W'(MAX_DIVISIONS) : ring_count_reg;
    assign sc   = (32'(sector_count_reg) > MAX_DIVISIONS) ? CNT_W'(MAX_DIVISIONS) : sector_count_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            r0_reg  <= r_in;
            s0_reg  <= s_in;
            rc0_reg <= rc;
            sc0_reg <= sc;
            v0_reg  <= (rc != '0) && (sc != '0) && (r_in <= rc) && (s_in <= sc);
            q0_reg  <= (rc != '0) && (sc != '0) && (r_in < rc) && (s_in < sc);
        end
    end

    // ---------------- dividers: phases and texture coords ----------------
    logic [PHASE_W-1:0] phi_ph, th_ph, u_quo, v_quo;
    logic [DIV_W-1:0]   th_rem;

    // sector == count wraps to a full turn, i.e. phase zero
    assign th_rem = (s0_reg == sc0_reg) ? '0 : DIV_W'(s0_reg);

    uvst_div u_div_phi (
        .aclk    (aclk),
        .en      (en[DIV_FIRST +: DIV_STAGES]),
        .rem_in  (DIV_W'(r0_reg)),
        .low_in  (PHASE_W'(rc0_reg)),
        .dvsr_in ({rc0_reg, 1'b0}),
        .quo_out (phi_ph)
    );

    uvst_div u_div_th (
        .aclk    (aclk),
        .en      (en[DIV_FIRST +: DIV_STAGES]),
        .rem_in  (th_rem),
        .low_in  (PHASE_W'(sc0_reg[CNT_W-1:1])),
        .dvsr_in (DIV_W'(sc0_reg)),
        .quo_out (th_ph)
    );

    // texture: rounding term scaled by 2^15, quotient shifted back down
    uvst_div u_div_u (
        .aclk    (aclk),
        .en      (en[DIV_FIRST +: DIV_STAGES]),
        .rem_in  (DIV_W'(s0_reg)),
        .low_in  ({9'd0, sc0_reg, 15'd0}),
        .dvsr_in ({sc0_reg, 1'b0}),
        .quo_out (u_quo)
    );

    uvst_div u_div_v (
        .aclk    (aclk),
        .en      (en[DIV_FIRST +: DIV_STAGES]),
        .rem_in  (DIV_W'(r0_reg)),
        .low_in  ({9'd0, rc0_reg, 15'd0}),
        .dvsr_in ({rc0_reg, 1'b0}),
        .quo_out (v_quo)
    );

    // ---------------- sine units ----------------
    logic [MAG_W-1:0] sp, cp, st, ct;
    logic             nsp, ncp, nst, nct;

    uvst_sine u_sin_phi (
        .aclk (aclk), .en (en[SIN_FIRST +: SIN_STAGES]),
        .phase_in (phi_ph), .mag_out (sp), .neg_out (nsp)
    );
    uvst_sine u_cos_phi (
        .aclk (aclk), .en (en[SIN_FIRST +: SIN_STAGES]),
        .phase_in (phi_ph + QUARTER_TURN), .mag_out (cp), .neg_out (ncp)
    );
    uvst_sine u_sin_th (
        .aclk (aclk), .en (en[SIN_FIRST +: SIN_STAGES]),
        .phase_in (th_ph), .mag_out (st), .neg_out (nst)
    );
    uvst_sine u_cos_th (
        .aclk (aclk), .en (en[SIN_FIRST +: SIN_STAGES]),
        .phase_in (th_ph + QUARTER_TURN), .mag_out (ct), .neg_out (nct)
    );

    // ---------------- side data delay lines ----------------
    meta_t meta_reg [DIV_FIRST:PROD_ST];
    tex_t  tex_reg  [SIN_FIRST:PROD_ST];
    meta_t meta_new;
    logic [IDX_W-1:0] tl;

    assign tl = 16'(r0_reg) * (16'(sc0_reg) + 16'd1) + 16'(s0_reg);

    always_comb begin
        meta_new = '0;
        meta_new.vertex_valid = v0_reg;
        meta_new.quad_valid   = q0_reg;
        if (q0_reg) begin
            meta_new.tl = tl;
            meta_new.tr = tl + 16'd1;
            meta_new.bl = tl + 16'(sc0_reg) + 16'd1;
            meta_new.br = tl + 16'(sc0_reg) + 16'd2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[DIV_FIRST]) meta_reg[DIV_FIRST] <= meta_new;
        for (int i = DIV_FIRST + 1; i <= PROD_ST; i++) begin
            if (en[i]) meta_reg[i] <= meta_reg[i-1];
        end
        if (en[SIN_FIRST]) tex_reg[SIN_FIRST] <= '{u: u_quo[31:15], v: v_quo[31:15]};
        for (int i = SIN_FIRST + 1; i <= PROD_ST; i++) begin
            if (en[i]) tex_reg[i] <= tex_reg[i-1];
        end
    end

    // ---------------- product stage ----------------
    logic [61:0] px_reg, py_reg, pz_reg;
    logic        nx_reg, ny_reg, nz_reg;

    always_ff @(posedge aclk) begin
        if (en[PROD_ST]) begin
            px_reg <= 62'(sp) * 62'(ct);
            pz_reg <= 62'(sp) * 62'(st);
            py_reg <= {1'b0, cp, 30'd0};
            nx_reg <= nsp ^ nct;
            ny_reg <= ncp;
            nz_reg <= nsp ^ nst;
        end
    end

    // ---------------- output stage: round, sign, gate ----------------
    function automatic logic [COORD_W-1:0] to_coord(logic [61:0] mag, logic neg);
        logic [61:0]        rnd;
        logic [COORD_W-1:0] v;
        rnd = (mag + (62'd1 << (SH - 1))) >> SH;
        v   = rnd[COORD_W-1:0];
        return neg ? COORD_W'(16'd0 - v) : v;
    endfunction

    logic [COORD_W-1:0] x_reg, y_reg, z_reg;
    tex_t               tex_out_reg;
    meta_t              meta_out_reg;
    logic               vv;

    assign vv = meta_reg[PROD_ST].vertex_valid;

    always_ff @(posedge aclk) begin
        if (en[OUT_ST]) begin
            x_reg        <= vv ? to_coord(px_reg, nx_reg) : '0;
            y_reg        <= vv ? to_coord(py_reg, ny_reg) : '0;
            z_reg        <= vv ? to_coord(pz_reg, nz_reg) : '0;
            tex_out_reg  <= vv ? tex_reg[PROD_ST] : '0;
            meta_out_reg <= meta_reg[PROD_ST];
        end
    end

    assign m_axis_tdata = {6'd0, meta_out_reg.br, meta_out_reg.bl, meta_out_reg.tr,
                           meta_out_reg.tl, tex_out_reg.v, tex_out_reg.u,
                           z_reg, y_reg, x_reg};
    assign m_axis_tuser = {meta_out_reg.quad_valid, meta_out_reg.vertex_valid};

endmodule

// ===== design/uvst_div.sv =====
// Pipelined restoring divider: (rem_in:low_in) / dvsr_in, 32 quotient bits.
// Depends on uvst_pkg.
module uvst_div
    import uvst_pkg::*;
(
    input  logic                  aclk,
    input  logic [DIV_STAGES-1:0] en,
    input  logic [DIV_W-1:0]      rem_in,   // must be below dvsr_in
    input  logic [PHASE_W-1:0]    low_in,
    input  logic [DIV_W-1:0]      dvsr_in,
    output logic [PHASE_W-1:0]    quo_out
);

    div_state_t       st_reg   [DIV_STAGES];
    logic [DIV_W-1:0] dvsr_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        div_state_t       st_in;
        logic [DIV_W-1:0] dv_in;
        if (k == 0) begin : g_first
            assign st_in = '{rem: rem_in, low: low_in, quo: '0};
            assign dv_in = dvsr_in;
        end else begin : g_rest
            assign st_in = st_reg[k-1];
            assign dv_in = dvsr_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                st_reg[k]   <= div_bits(st_in, dv_in);
                dvsr_reg[k] <= dv_in;
            end
        end
    end

    assign quo_out = st_reg[DIV_STAGES-1].quo;

endmodule

// ===== design/uvst_sine.sv =====
// Pipelined sine of a 32-bit phase: quadrant fold, Horner series, Q30 magnitude and sign.
// Depends on uvst_pkg.
module uvst_sine
    import uvst_pkg::*;
(
    input  logic                  aclk,
    input  logic [SIN_STAGES-1:0] en,
    input  logic [PHASE_W-1:0]    phase_in,
    output logic [MAG_W-1:0]      mag_out,
    output logic                  neg_out
);

    logic [MAG_W-1:0] q_reg   [SIN_STAGES];
    logic [MAG_W-1:0] q2_reg  [SIN_STAGES];
    logic [MAG_W-1:0] acc_reg [SIN_STAGES];
    logic             neg_reg [SIN_STAGES];
    logic [MAG_W-1:0] q_fold;
    logic [61:0]      sq;
    logic [61:0]      last_prod;
    logic [31:0]      last_t;

    assign q_fold = phase_in[30] ? (Q30_ONE - {1'b0, phase_in[29:0]})
                                 : {1'b0, phase_in[29:0]};

    // stage 0: fold to first quadrant
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            q_reg[0]   <= q_fold;
            neg_reg[0] <= phase_in[31];
        end
    end

    // stage 1: q squared
    assign sq = 62'(q_reg[0]) * 62'(q_reg[0]);
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            q_reg[1]   <= q_reg[0];
            neg_reg[1] <= neg_reg[0];
            q2_reg[1]  <= sq[60:30];
        end
    end

    // stages 2..7: one Horner step each
    for (genvar j = 2; j < SIN_STAGES - 1; j++) begin : g_horner
        logic [MAG_W-1:0] src;
        logic [61:0]      p;
        if (j == 2) begin : g_seed
            assign src = SIN_COEF[6];
        end else begin : g_chain
            assign src = acc_reg[j-1];
        end
        assign p = 62'(src) * 62'(q2_reg[j-1]);
        always_ff @(posedge aclk) begin
            if (en[j]) begin
                q_reg[j]   <= q_reg[j-1];
                q2_reg[j]  <= q2_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                acc_reg[j] <= MAG_W'({1'b0, SIN_COEF[7-j]} - p[61:30]);
            end
        end
    end

    // last stage: times q, clamp to one
    assign last_prod = 62'(acc_reg[SIN_STAGES-2]) * 62'(q_reg[SIN_STAGES-2]);
    assign last_t    = last_prod[61:30];
    always_ff @(posedge aclk) begin
        if (en[SIN_STAGES-1]) begin
            neg_reg[SIN_STAGES-1] <= neg_reg[SIN_STAGES-2];
            acc_reg[SIN_STAGES-1] <= (last_t > {1'b0, Q30_ONE}) ? Q30_ONE : last_t[MAG_W-1:0];
        end
    end

    assign mag_out = acc_reg[SIN_STAGES-1];
    assign neg_out = neg_reg[SIN_STAGES-1];

endmodule

// ===== design/uvst_chk.sv =====
// Port-level checker for the UV sphere tessellator, bound to the top level.
// Depends on uv_sphere_tessellator_defines.svh.
`include "uv_sphere_tessellator_defines.svh"

module uvst_chk (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [151:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    `UVST_ASSERT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `UVST_ASSERT(a_off_grid_zero, aclk, aresetn, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0, "off-grid point carries data")
    `UVST_ASSERT(a_quad_in_grid, aclk, aresetn, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0], "quad flagged outside grid")
    `UVST_ASSERT(a_quad_corners, aclk, aresetn, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[113:98] == m_axis_tdata[97:82] + 16'd1 && m_axis_tdata[145:130] == m_axis_tdata[129:114] + 16'd1, "corner indices out of step")
    `UVST_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_axis_tvalid, "result after reset")

endmodule

bind uv_sphere_tessellator uvst_chk u_uvst_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
